[src/cdb_pkg.sv]
// Shared types, constants and helper functions of the circular deque buffer.
package cdb_pkg;

  // Storage geometry.
  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 8;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register map, indexed by the word address.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ_FRONT = 3'd4,
    REQ_READ_BACK  = 3'd5,
    REQ_REMOVE     = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_e;

  // Configuration state handed to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] cap;    // effective capacity, 1..DEPTH
    logic             clear;  // capacity written this cycle
  } cfg_t;

  // One access of the slot memory.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  // Reduces a value below twice the capacity into the range 0..cap-1.
  function automatic logic [PTR_W-1:0] wrap_mod(input logic [CNT_W:0]   val,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] diff;
    diff = val - {1'b0, cap};
    return (val >= {1'b0, cap}) ? diff[PTR_W-1:0] : val[PTR_W-1:0];
  endfunction

endpackage

[src/cdb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module cdb_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/cdb_cfg.sv]
// Configuration register block of the circular deque buffer.
module cdb_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdb_pkg::APB_AW-1:0] paddr,
  input  logic [cdb_pkg::APB_DW-1:0] pwdata,
  output logic [cdb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output cdb_pkg::cfg_t              cfg_o
);

  logic [cdb_pkg::CNT_W-1:0] capacity_q;
  logic [cdb_pkg::CNT_W-1:0] cap_eff_q;
  logic [cdb_pkg::CNT_W-1:0] cap_raw;
  logic [cdb_pkg::CNT_W-1:0] cap_eff_d;
  logic                      wr_en;
  logic                      cap_wr;

  // Write strobe at the access phase.
  assign wr_en   = psel && penable && pwrite;
  assign cap_wr  = wr_en && (paddr[2] == cdb_pkg::REG_CAPACITY);
  assign cap_raw = pwdata[cdb_pkg::CNT_W-1:0];

  // Clamp the written capacity into 1..DEPTH.
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff_d = cdb_pkg::CNT_W'(1);
    end else if (cap_raw > cdb_pkg::CNT_W'(cdb_pkg::DEPTH)) begin
      cap_eff_d = cdb_pkg::CNT_W'(cdb_pkg::DEPTH);
    end else begin
      cap_eff_d = cap_raw;
    end
  end

  // Capacity register, raw and clamped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= cdb_pkg::CAP_RESET;
      cap_eff_q  <= cdb_pkg::CAP_RESET;
    end else if (cap_wr) begin
      capacity_q <= cap_raw;
      cap_eff_q  <= cap_eff_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (paddr[2])
      cdb_pkg::REG_CAPACITY: prdata = {(cdb_pkg::APB_DW - cdb_pkg::CNT_W)'(0), capacity_q};
      default:               prdata = '0;
    endcase
  end

  assign pready       = 1'b1;
  assign cfg_o.cap    = cap_eff_q;
  assign cfg_o.clear  = cap_wr;

endmodule

[src/cdb_ctrl.sv]
// Request sequencer of the circular deque buffer: pointers, fill level and memory accesses.
module cdb_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdb_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        req_type_i,
  input  logic [cdb_pkg::DATA_W-1:0]        data_in_i,
  input  logic [cdb_pkg::CNT_W-1:0]         count_i,
  input  logic [cdb_pkg::PTR_W-1:0]         index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic [cdb_pkg::DATA_W-1:0]        data_out_o,
  output logic [cdb_pkg::CNT_W-1:0]         used_o,
  output logic [cdb_pkg::CNT_W-1:0]         free_slots_o,
  output cdb_pkg::mem_req_t                 mem_o,
  input  logic [cdb_pkg::DATA_W-1:0]        rdata_i
);

  localparam int PW = cdb_pkg::PTR_W;
  localparam int CW = cdb_pkg::CNT_W;
  localparam int DW = cdb_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e             state_q;
  logic [PW-1:0]      head_q;
  logic [PW-1:0]      tail_q;
  logic [CW-1:0]      fill_q;
  logic [PW-1:0]      abs_q;
  logic               out_valid_q;
  logic               ok_q;
  logic [DW-1:0]      data_q;
  logic [CW-1:0]      used_q;
  logic [CW-1:0]      free_q;

  // Latched request.
  cdb_pkg::req_e      req_q;
  logic [DW-1:0]      din_q;
  logic [CW-1:0]      cnt_q;
  logic [PW-1:0]      idx_q;

  // Execute-step results.
  logic [CW-1:0]      cap;
  logic [PW-1:0]      cap_m1;
  logic [PW-1:0]      h;
  logic [PW-1:0]      t;
  logic [CW-1:0]      f;
  logic [PW-1:0]      head_d;
  logic [PW-1:0]      tail_d;
  logic [CW-1:0]      fill_d;
  logic               ok_d;
  logic               need_rd;
  logic [PW-1:0]      rd_addr;
  logic               exec_we;
  logic [PW-1:0]      exec_waddr;
  logic [PW-1:0]      abs_d;
  logic [CW-1:0]      back_pos;
  logic [CW-1:0]      idx_ext;
  logic               out_free;
  logic               res_load;
  logic               ptr_load;

  assign cap      = cfg_i.cap;
  assign cap_m1   = PW'(cap - CW'(1));
  assign idx_ext  = {1'b0, idx_q};
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode one request against the current pointers.
  always_comb begin
    // State that no longer fits the capacity counts as empty.
    if (fill_q > cap || {1'b0, head_q} >= cap || {1'b0, tail_q} >= cap) begin
      h = '0;
      t = '0;
      f = '0;
    end else begin
      h = head_q;
      t = tail_q;
      f = fill_q;
    end

    head_d     = h;
    tail_d     = t;
    fill_d     = f;
    ok_d       = 1'b0;
    need_rd    = 1'b0;
    rd_addr    = '0;
    exec_we    = 1'b0;
    exec_waddr = t;
    abs_d      = '0;
    back_pos   = ((idx_ext + CW'(1)) == cap) ? '0 : (idx_ext + CW'(1));

    case (req_q)
      cdb_pkg::REQ_PUSH_BACK: begin
        if (f < cap) begin
          exec_we    = 1'b1;
          exec_waddr = t;
          tail_d     = (({1'b0, t} + CW'(1)) == cap) ? '0 : (t + PW'(1));
          fill_d     = f + CW'(1);
          ok_d       = 1'b1;
        end
      end
      cdb_pkg::REQ_PUSH_FRONT: begin
        if (f < cap) begin
          head_d     = (h == '0) ? cap_m1 : (h - PW'(1));
          exec_we    = 1'b1;
          exec_waddr = head_d;
          fill_d     = f + CW'(1);
          ok_d       = 1'b1;
        end
      end
      cdb_pkg::REQ_POP_BACK: begin
        if (f != '0) begin
          ok_d = 1'b1;
          if (cnt_q >= f) begin
            head_d = '0;
            tail_d = '0;
            fill_d = '0;
          end else begin
            fill_d = f - cnt_q;
            tail_d = cdb_pkg::wrap_mod({2'b0, t} + {1'b0, cap} - {1'b0, cnt_q}, cap);
          end
        end
      end
      cdb_pkg::REQ_POP_FRONT: begin
        if (f != '0) begin
          ok_d = 1'b1;
          if (cnt_q >= f) begin
            head_d = '0;
            tail_d = '0;
            fill_d = '0;
          end else begin
            fill_d = f - cnt_q;
            head_d = cdb_pkg::wrap_mod({2'b0, h} + {1'b0, cnt_q}, cap);
          end
        end
      end
      cdb_pkg::REQ_READ_FRONT: begin
        if (idx_ext < f) begin
          ok_d    = 1'b1;
          need_rd = 1'b1;
          rd_addr = cdb_pkg::wrap_mod({2'b0, h} + {2'b0, idx_q}, cap);
        end
      end
      cdb_pkg::REQ_READ_BACK: begin
        if (idx_ext < f) begin
          ok_d    = 1'b1;
          need_rd = 1'b1;
          rd_addr = cdb_pkg::wrap_mod({2'b0, t} + {1'b0, cap} - {1'b0, back_pos}, cap);
        end
      end
      cdb_pkg::REQ_REMOVE: begin
        if (f != '0 && idx_ext < f) begin
          ok_d = 1'b1;
          if (f <= CW'(1)) begin
            head_d = '0;
            tail_d = '0;
            fill_d = '0;
          end else begin
            // Move the last element into the removed slot.
            abs_d   = cdb_pkg::wrap_mod({2'b0, h} + {2'b0, idx_q}, cap);
            tail_d  = (t == '0) ? cap_m1 : (t - PW'(1));
            fill_d  = f - CW'(1);
            rd_addr = tail_d;
            need_rd = (abs_d != tail_d);
          end
        end
      end
      cdb_pkg::REQ_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        fill_d = '0;
        ok_d   = 1'b1;
      end
    endcase
  end

  // A result is loaded when the execute or the read step completes.
  assign res_load = ((state_q == S_EXEC) && !need_rd && out_free) ||
                    ((state_q == S_READ) && out_free);

  // Pointers move at the end of the execute step.
  assign ptr_load = (state_q == S_EXEC) && (need_rd || out_free);

  // Memory accesses: reads and pushes in the execute step, the moved element afterward.
  always_comb begin
    mem_o.re    = (state_q == S_EXEC) && need_rd;
    mem_o.raddr = rd_addr;
    if (state_q == S_READ) begin
      mem_o.we    = out_free && (req_q == cdb_pkg::REQ_REMOVE);
      mem_o.waddr = abs_q;
      mem_o.wdata = rdata_i;
    end else begin
      mem_o.we    = (state_q == S_EXEC) && exec_we && out_free;
      mem_o.waddr = exec_waddr;
      mem_o.wdata = din_q;
    end
  end

  // Request payload latch.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= cdb_pkg::req_e'(req_type_i);
      din_q <= data_in_i;
      cnt_q <= count_i;
      idx_q <= index_i;
    end
    if (state_q == S_EXEC) begin
      abs_q <= abs_d;
    end
  end

  // Sequencer, pointer registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      data_q      <= '0;
      used_q      <= '0;
      free_q      <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (need_rd) begin
            state_q <= S_READ;
          end else if (out_free) begin
            ok_q    <= ok_d;
            data_q  <= '0;
            used_q  <= fill_d;
            free_q  <= cap - fill_d;
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            ok_q    <= 1'b1;
            data_q  <= (req_q == cdb_pkg::REQ_REMOVE) ? '0 : rdata_i;
            used_q  <= fill_q;
            free_q  <= cap - fill_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // A capacity write empties the deque.
      if (cfg_i.clear) begin
        head_q <= '0;
        tail_q <= '0;
        fill_q <= '0;
      end else if (ptr_load) begin
        head_q <= head_d;
        tail_q <= tail_d;
        fill_q <= fill_d;
      end
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign data_out_o   = data_q;
  assign used_o       = used_q;
  assign free_slots_o = free_q;

  // The fill level never exceeds the effective capacity.
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap)
    else $error("fill level above capacity");

  // A failed request never carries data.
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (data_q == '0))
    else $error("failed request returned data");

  // Used and free of a valid result add up to the capacity.
  a_used_free_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (({1'b0, used_q} + {1'b0, free_q}) == {1'b0, cap}))
    else $error("used plus free differs from capacity");

  // The memory is never read and written in the same cycle.
  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && mem_o.re))
    else $error("memory read and write collide");

endmodule

[src/circular_deque_buffer_unit.sv]
// Circular deque buffer: a double-ended byte queue held in a 1024-entry slot memory.
//
// Requests enter on the input channel (in_valid_i / in_stall_o) with req_type_i,
// data_in_i, count_i and index_i; each request gives exactly one result on the
// output channel (out_valid_o / out_stall_i) with ok_o, data_out_o, used_o and
// free_slots_o. An item is taken at a clock edge where valid is high and stall low.
// The block works on one request at a time. Pushes, pops, clears, failed requests and
// removes that need no element move register their result from the execute step;
// successful reads and removes that move the last element first go on to a read step
// for the registered read of the slot memory. A new item is taken in the cycle after
// the previous result is registered, so each request is finished before the next is
// taken. A result waits in its output register while the receiver stalls; the block
// then holds the next item's execution until that register is taken. The capacity
// register (APB, byte address 0) sets the slots in use, 1..1024; writing it empties the
// deque. It must be written only while the block is idle; the user, not the block,
// enforces this. Reset empties the deque and sets the capacity to 1024. Slot contents
// are not cleared, so no clearing pass is needed; only written slots are ever read.
module circular_deque_buffer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdb_pkg::APB_AW-1:0] paddr,
  input  logic [cdb_pkg::APB_DW-1:0] pwdata,
  output logic [cdb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [cdb_pkg::DATA_W-1:0] data_in_i,
  input  logic [cdb_pkg::CNT_W-1:0]  count_i,
  input  logic [cdb_pkg::PTR_W-1:0]  index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic [cdb_pkg::DATA_W-1:0] data_out_o,
  output logic [cdb_pkg::CNT_W-1:0]  used_o,
  output logic [cdb_pkg::CNT_W-1:0]  free_slots_o
);

  cdb_pkg::cfg_t                cfg;
  cdb_pkg::mem_req_t            mem_req;
  logic [cdb_pkg::DATA_W-1:0]   rdata;

  // Configuration registers.
  cdb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Request sequencer.
  cdb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_in_i    (data_in_i),
    .count_i      (count_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .data_out_o   (data_out_o),
    .used_o       (used_o),
    .free_slots_o (free_slots_o),
    .mem_o        (mem_req),
    .rdata_i      (rdata)
  );

  // Slot memory.
  cdb_ram #(
    .DATA_W (cdb_pkg::DATA_W),
    .ADDR_W (cdb_pkg::PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule
